// File: hw/rtl/dq_pkg.sv
// shared opcode and status codes for the double-ended queue
package dq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_INDEX = 3'd4,
    OP_CLEAR      = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// File: hw/rtl/dq_ram.sv
// generic single-write, single-read ram with registered read data
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old content on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/double_ended_queue_top.sv
// double-ended queue top level: control, three store copies, result register
// an accepted input transaction passes the s1 registers and then the output register to out_tvalid
// throughput: one transaction per cycle while out_tready does not stall the output; one copy of the store per read port
//   (indexed read, front, back), so all three reads happen in the accept cycle
// reset clears head, count and all valid flags; the element store is not
//   cleared and needs no clearing pass (only live entries are ever shown)
module double_ended_queue_top #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IDX_W      = $clog2(CAPACITY),
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1),
  localparam int unsigned IN_BITS    = dq_pkg::OPCODE_W + DATA_WIDTH + IDX_W,
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = 3 * DATA_WIDTH + CNT_W + dq_pkg::STATUS_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode, push_value, read_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value, front_value, back_value, element_count, status
  output logic [OUT_DATA_W-1:0] out_tdata
);

  import dq_pkg::*;

  localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  // input fields
  logic [OPCODE_W-1:0]   in_opcode;
  logic [DATA_WIDTH-1:0] in_push_value;
  logic [IDX_W-1:0]      in_read_index;

  assign in_opcode     = in_tdata[OPCODE_W-1:0];
  assign in_push_value = in_tdata[OPCODE_W +: DATA_WIDTH];
  assign in_read_index = in_tdata[OPCODE_W + DATA_WIDTH +: IDX_W];

  // queue state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // decode results
  status_t          status;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_ok;
  logic [IDX_W-1:0] front_addr;
  logic [IDX_W-1:0] back_addr;
  logic             is_full;
  logic             is_empty;
  logic             in_accept;

  // pipeline control
  logic                  s1_valid_r;
  logic                  s1_advance;
  status_t               s1_status_r;
  logic [CNT_W-1:0]      s1_count_r;
  logic                  s1_rd_ok_r;
  logic                  s1_byp_front_r;
  logic                  s1_byp_back_r;
  logic [DATA_WIDTH-1:0] s1_byp_value_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_DATA_W-1:0] out_tdata_nxt;

  logic [DATA_WIDTH-1:0] ram_rd_data;
  logic [DATA_WIDTH-1:0] ram_front_data;
  logic [DATA_WIDTH-1:0] ram_back_data;
  logic [DATA_WIDTH-1:0] read_value;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_accept  = in_tvalid && in_tready;

  assign is_full  = (count_r == CAP_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = wrap_add(head_r, count_r);
    rd_addr   = wrap_add(head_r, CNT_W'(in_read_index));
    rd_ok     = 1'b0;
    unique case (opcode_t'(in_opcode))
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
          wr_addr   = head_nxt;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ_INDEX: begin
        if (CNT_W'(in_read_index) >= count_r) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    // an empty queue always restarts at slot zero
    if (count_nxt == '0) begin
      head_nxt = '0;
    end
  end

  assign front_addr = head_nxt;
  assign back_addr  = wrap_add(head_nxt, count_nxt - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (in_accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // three copies of the store, written alike, one read port each
  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram_read (
    .clk   (clk),
    .we    (in_accept && wr_en),
    .waddr (wr_addr),
    .wdata (in_push_value),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rd_data)
  );

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram_front (
    .clk   (clk),
    .we    (in_accept && wr_en),
    .waddr (wr_addr),
    .wdata (in_push_value),
    .re    (in_accept),
    .raddr (front_addr),
    .rdata (ram_front_data)
  );

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram_back (
    .clk   (clk),
    .we    (in_accept && wr_en),
    .waddr (wr_addr),
    .wdata (in_push_value),
    .re    (in_accept),
    .raddr (back_addr),
    .rdata (ram_back_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // the ram returns old data for the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status_r    <= status;
      s1_count_r     <= count_nxt;
      s1_rd_ok_r     <= rd_ok;
      s1_byp_front_r <= wr_en && (wr_addr == front_addr);
      s1_byp_back_r  <= wr_en && (wr_addr == back_addr);
      s1_byp_value_r <= in_push_value;
    end
  end

  always_comb begin
    read_value  = s1_rd_ok_r ? ram_rd_data : '0;
    front_value = '0;
    back_value  = '0;
    if (s1_count_r != '0) begin
      front_value = s1_byp_front_r ? s1_byp_value_r : ram_front_data;
      back_value  = s1_byp_back_r ? s1_byp_value_r : ram_back_data;
    end
    out_tdata_nxt = OUT_DATA_W'({s1_status_r, s1_count_r, back_value, front_value,
                                 read_value});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("element count above capacity");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0))
    else $error("empty queue with nonzero head");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_opcode == OP_POP_FRONT || in_opcode == OP_POP_BACK)
     && count_r != '0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not decrement count");

endmodule
